// ----- src/aqas_pkg.sv -----
// Shared types, widths and constants of the adaptive air-quality smoother.
`timescale 1ns / 1ps
package aqas_pkg;

    // Field widths
    localparam int SIAQ_W = 17;
    localparam int ACC_W  = 2;
    localparam int HUM_W  = 15;
    localparam int PRES_W = 17;
    localparam int GAS_W  = 26;
    localparam int MEAN_W = 24;
    localparam int VAR_W  = 40;
    localparam int D2_W   = 34;
    localparam int T_W    = 41;
    localparam int WGT_W  = 16;
    localparam int CFG_W  = 17;
    localparam int CFGA_W = 3;

    // Serial multiplier: multiplier operand, multiplicand, product
    localparam int MA_W = 24;
    localparam int MB_W = 41;
    localparam int MP_W = 65;

    localparam int RING_DEPTH_DEF = 8;

    // Register indexes
    localparam logic [CFGA_W-1:0] CFG_GAS_ALPHA = 3'd0;
    localparam logic [CFGA_W-1:0] CFG_VAR_ALPHA = 3'd1;
    localparam logic [CFGA_W-1:0] CFG_DECIM     = 3'd2;
    localparam logic [CFGA_W-1:0] CFG_PRESS_TH  = 3'd3;
    localparam logic [CFGA_W-1:0] CFG_HUMID_TH  = 3'd4;
    localparam logic [CFGA_W-1:0] CFG_IAQ_TH    = 3'd5;
    localparam logic [CFGA_W-1:0] CFG_RESUME    = 3'd6;

    // Weight mapping, Q0.16
    localparam logic [WGT_W-1:0]  A_LOW      = 16'd6554;
    localparam logic [WGT_W-1:0]  A_HIGH     = 16'd29491;
    localparam logic [WGT_W-1:0]  A_MIN      = 16'd5243;
    localparam logic [WGT_W-1:0]  A_FLOOR_LA = 16'd18350;
    localparam logic [SIAQ_W-1:0] V_LOW      = 17'd512;
    localparam logic [SIAQ_W-1:0] V_HIGH     = 17'd6400;
    localparam logic [MB_W-1:0]   A_SPAN     = 41'd22937;
    localparam logic [MB_W-1:0]   A_SCALE3   = 41'd39322;
    // ceil(2^28 / 23): floor(n / 23) = (n * RECIP23) >> 28 for n below 2^21
    localparam logic [MB_W-1:0]   RECIP23    = 41'd11671107;
    localparam logic [MP_W-1:0]   RND_HALF   = 65'd32768;
    localparam logic [16:0]       W_ONE      = 17'd65536;
    localparam logic [SIAQ_W-1:0] VOL_MAX    = 17'h1FFFF;

    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
        logic [MP_W-1:0] c;
    } t_mul_req;

endpackage

// ----- src/air_quality_adaptive_smoother_core.sv -----
// Top level of the adaptive air-quality smoother: sequencer, state and ring.
`timescale 1ns / 1ps
// Usage
//   Input beats arrive on s_axis_*: one environmental sample per beat
//   (static IAQ, accuracy, humidity, pressure, gas resistance).  Each beat
//   gives exactly one result beat on m_axis_* (gas average, smoothed IAQ,
//   accuracy, volatility, frozen flag).
//   Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata while
//   the block is idle; an index past the register list is ignored.
// Processing
//   One beat is processed at a time by a sequencer around a shared serial
//   multiply-accumulate unit (one multiplier bit per cycle, stopping early
//   when the remaining bits are zero) and a 20-step square-root unit.
//   The time from accept to result is set by the multiplier bit counts of
//   up to twelve products plus the root.  s_axis_tready is high only
//   between samples.
// Reset
//   Synchronous, active low: registers return to their defaults, the
//   averages restart (next sample seeds them) and the ring empties.
// Back-pressure
//   The result sits in an output register; the next sample is accepted
//   while it waits.  A finished sample is held until that register frees.
module air_quality_adaptive_smoother_core import aqas_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [16:0] static_iaq, [18:17] accuracy, [33:19] humidity,
    // [50:34] pressure_pa, [76:51] gas_ohm, [79:77] zero
    input  logic [79:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [25:0] gas_average, [42:26] iaq_display, [44:43] accuracy_display,
    // [61:45] volatility, [62] frozen, [63] zero
    output logic [63:0]       m_axis_tdata,
    input  logic              i_cfg_we,
    input  logic [CFGA_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);
    localparam int RA_W = $clog2(RING_DEPTH);
    localparam int RF_W = $clog2(RING_DEPTH + 1);
    localparam int RD_W = PRES_W + HUM_W + SIAQ_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_GAS1  = 5'd1;
    localparam logic [4:0] S_GAS2  = 5'd2;
    localparam logic [4:0] S_D2    = 5'd3;
    localparam logic [4:0] S_MEAN1 = 5'd4;
    localparam logic [4:0] S_MEAN2 = 5'd5;
    localparam logic [4:0] S_VAR1  = 5'd6;
    localparam logic [4:0] S_VAR2  = 5'd7;
    localparam logic [4:0] S_SQRT  = 5'd8;
    localparam logic [4:0] S_WGT   = 5'd9;
    localparam logic [4:0] S_DIV   = 5'd10;
    localparam logic [4:0] S_SCALE = 5'd11;
    localparam logic [4:0] S_CLAMP = 5'd12;
    localparam logic [4:0] S_SM1   = 5'd13;
    localparam logic [4:0] S_SM2   = 5'd14;
    localparam logic [4:0] S_RING  = 5'd15;
    localparam logic [4:0] S_CMP   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    // Configuration registers
    logic [15:0]       r_gas_alpha;
    logic [15:0]       r_var_alpha;
    logic [7:0]        r_decim;
    logic [15:0]       r_press_th;
    logic [HUM_W-1:0]  r_humid_th;
    logic [SIAQ_W-1:0] r_iaq_th;
    logic [7:0]        r_resume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_alpha <= 16'd6554;
            r_var_alpha <= 16'd6554;
            r_decim     <= 8'd10;
            r_press_th  <= 16'd50;
            r_humid_th  <= 15'd1280;
            r_iaq_th    <= 17'd5120;
            r_resume    <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAS_ALPHA: r_gas_alpha <= i_cfg_wdata[15:0];
                CFG_VAR_ALPHA: r_var_alpha <= i_cfg_wdata[15:0];
                CFG_DECIM:     r_decim     <= i_cfg_wdata[7:0];
                CFG_PRESS_TH:  r_press_th  <= i_cfg_wdata[15:0];
                CFG_HUMID_TH:  r_humid_th  <= i_cfg_wdata[HUM_W-1:0];
                CFG_IAQ_TH:    r_iaq_th    <= i_cfg_wdata;
                CFG_RESUME:    r_resume    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer and block state
    logic [4:0]        r_state;
    logic              r_wait;
    logic              r_seeded;
    logic [GAS_W-1:0]  r_gas_avg;
    logic [MEAN_W-1:0] r_mean;
    logic [VAR_W-1:0]  r_var;
    logic [SIAQ_W-1:0] r_smooth;
    logic [7:0]        r_dcnt;
    logic [RA_W-1:0]   r_wr;
    logic [RF_W-1:0]   r_fill;
    logic              r_frozen;
    logic [7:0]        r_stable;

    // Per-sample working registers
    logic [SIAQ_W-1:0] r_siaq;
    logic [ACC_W-1:0]  r_acc;
    logic [HUM_W-1:0]  r_hum;
    logic [PRES_W-1:0] r_pres;
    logic [GAS_W-1:0]  r_gas;
    logic [D2_W-1:0]   r_d2;
    logic [T_W-1:0]    r_t;
    logic [SIAQ_W-1:0] r_vol;
    logic [19:0]       r_n;
    logic [WGT_W-1:0]  r_wgt;

    // Output register
    logic              r_ovalid;
    logic [63:0]       r_odata;

    t_mul_req          mreq;
    logic              mul_done;
    logic [MP_W-1:0]   mul_prod;
    logic              sq_done;
    logic [VAR_W/2-1:0] sq_root;
    logic              sq_start;
    logic              mul_op;
    logic              unit_fin;
    logic              in_acc;
    logic [MEAN_W-1:0] x_in;
    logic [MEAN_W-1:0] x_cur;
    logic [MEAN_W-1:0] dmag;
    logic [8:0]        dcnt_n;
    logic [RA_W-1:0]   wr_n;
    logic [RF_W-1:0]   fill_n;
    logic [RA_W-1:0]   old_addr;
    logic              ram_we;
    logic [RD_W-1:0]   ram_rdata;
    logic [PRES_W-1:0] old_pres;
    logic [HUM_W-1:0]  old_hum;
    logic [SIAQ_W-1:0] old_iaq;
    logic              moving;
    logic [7:0]        stable_n;
    logic [WGT_W-1:0]  wgt_lo;
    logic [WGT_W-1:0]  wgt_cl;
    logic [PRES_W-1:0] dp;
    logic [HUM_W-1:0]  dh;
    logic [SIAQ_W-1:0] di;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign x_in   = {s_axis_tdata[16:0], 7'b0};
    assign x_cur  = {r_siaq, 7'b0};
    assign dmag   = (x_cur >= r_mean) ? (x_cur - r_mean) : (r_mean - x_cur);

    // Decimation and ring pointers
    assign dcnt_n   = {1'b0, r_dcnt} + 9'd1;
    assign wr_n     = (r_wr == RA_W'(RING_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign fill_n   = (r_fill == RF_W'(RING_DEPTH)) ? r_fill : r_fill + 1'b1;
    assign old_addr = (fill_n == RF_W'(RING_DEPTH)) ? wr_n : '0;
    assign ram_we   = (r_state == S_RING) && (dcnt_n >= {1'b0, r_decim});

    assign {old_iaq, old_hum, old_pres} = ram_rdata;
    assign dp = (r_pres >= old_pres) ? r_pres - old_pres : old_pres - r_pres;
    assign dh = (r_hum >= old_hum) ? r_hum - old_hum : old_hum - r_hum;
    assign di = (r_siaq >= old_iaq) ? r_siaq - old_iaq : old_iaq - r_siaq;
    assign moving = ({1'b0, dp} > {2'b0, r_press_th}) || (dh > r_humid_th) ||
                    (di > r_iaq_th);
    assign stable_n = (r_stable != 8'hFF) ? r_stable + 8'd1 : r_stable;

    // Accuracy floor and final clamp of the IAQ weight
    assign wgt_lo = ((r_acc <= 2'd1) && (r_wgt < A_FLOOR_LA)) ? A_FLOOR_LA : r_wgt;
    assign wgt_cl = (wgt_lo < A_MIN) ? A_MIN : ((wgt_lo > A_HIGH) ? A_HIGH : wgt_lo);

    // Operand selection for the shared multiplier
    always_comb begin
        mul_op = 1'b0;
        mreq.a = '0;
        mreq.b = '0;
        mreq.c = '0;
        case (r_state)
            S_GAS1: begin
                mul_op = r_seeded;
                mreq.a = MA_W'(r_gas_alpha);
                mreq.b = MB_W'(r_gas);
                mreq.c = RND_HALF;
            end
            S_GAS2: begin
                mul_op = 1'b1;
                mreq.a = MA_W'(W_ONE - {1'b0, r_gas_alpha});
                mreq.b = MB_W'(r_gas_avg);
                mreq.c = mul_prod;
            end
            S_D2: begin
                mul_op = 1'b1;
                mreq.a = dmag;
                mreq.b = MB_W'(dmag);
            end
            S_MEAN1: begin
                mul_op = 1'b1;
                mreq.a = MA_W'(r_var_alpha);
                mreq.b = MB_W'(x_cur);
                mreq.c = RND_HALF;
            end
            S_MEAN2: begin
                mul_op = 1'b1;
                mreq.a = MA_W'(W_ONE - {1'b0, r_var_alpha});
                mreq.b = MB_W'(r_mean);
                mreq.c = mul_prod;
            end
            S_VAR1: begin
                mul_op = 1'b1;
                mreq.a = MA_W'(r_var_alpha);
                mreq.b = MB_W'(r_d2);
            end
            S_VAR2: begin
                mul_op = 1'b1;
                mreq.a = MA_W'(W_ONE - {1'b0, r_var_alpha});
                mreq.b = r_t;
            end
            S_WGT: begin
                mul_op = (r_vol > V_LOW) && (r_vol < V_HIGH);
                mreq.a = MA_W'(r_vol - V_LOW);
                mreq.b = A_SPAN;
            end
            S_DIV: begin
                mul_op = 1'b1;
                mreq.a = MA_W'(r_n);
                mreq.b = RECIP23;
            end
            S_SCALE: begin
                mul_op = (r_acc == 2'd3);
                mreq.a = MA_W'(r_wgt);
                mreq.b = A_SCALE3;
            end
            S_SM1: begin
                mul_op = r_seeded;
                mreq.a = MA_W'(r_wgt);
                mreq.b = MB_W'(r_siaq);
                mreq.c = RND_HALF;
            end
            S_SM2: begin
                mul_op = 1'b1;
                mreq.a = MA_W'(W_ONE - {1'b0, r_wgt});
                mreq.b = MB_W'(r_smooth);
                mreq.c = mul_prod;
            end
            default: ;
        endcase
        mreq.start = mul_op && !r_wait;
    end

    assign sq_start = (r_state == S_SQRT) && !r_wait;
    assign unit_fin = r_wait && (mul_done || sq_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_seeded <= 1'b0;
            r_mean   <= '0;
            r_var    <= '0;
            r_smooth <= '0;
            r_gas_avg <= '0;
            r_dcnt   <= '0;
            r_wr     <= '0;
            r_fill   <= '0;
            r_frozen <= 1'b0;
            r_stable <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // hold the issue flag while a unit runs
            if ((mul_op || r_state == S_SQRT) && !r_wait) begin
                r_wait <= 1'b1;
            end else if (unit_fin) begin
                r_wait <= 1'b0;
            end
            // load a finished sample, else drop the beat once taken
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_siaq <= s_axis_tdata[16:0];
                        r_acc  <= s_axis_tdata[18:17];
                        r_hum  <= s_axis_tdata[33:19];
                        r_pres <= s_axis_tdata[50:34];
                        r_gas  <= s_axis_tdata[76:51];
                        // first sample seeds the averages
                        if (!r_seeded) begin
                            r_gas_avg <= s_axis_tdata[76:51];
                            r_mean    <= x_in;
                            r_var     <= '0;
                            r_smooth  <= s_axis_tdata[16:0];
                        end
                        r_state <= S_GAS1;
                    end
                end
                S_GAS1: begin
                    if (!r_seeded) begin
                        r_state <= S_D2;
                    end else if (unit_fin) begin
                        r_state <= S_GAS2;
                    end
                end
                S_GAS2: begin
                    if (unit_fin) begin
                        r_gas_avg <= mul_prod[16 +: GAS_W];
                        r_state   <= S_D2;
                    end
                end
                S_D2: begin
                    if (unit_fin) begin
                        r_d2    <= mul_prod[14 +: D2_W];
                        r_state <= S_MEAN1;
                    end
                end
                S_MEAN1: begin
                    if (unit_fin) begin
                        r_state <= S_MEAN2;
                    end
                end
                S_MEAN2: begin
                    if (unit_fin) begin
                        r_mean  <= mul_prod[16 +: MEAN_W];
                        r_state <= S_VAR1;
                    end
                end
                S_VAR1: begin
                    if (unit_fin) begin
                        r_t     <= {1'b0, r_var} + T_W'(mul_prod[16 +: D2_W]);
                        r_state <= S_VAR2;
                    end
                end
                S_VAR2: begin
                    if (unit_fin) begin
                        // saturate the variance at its width
                        if (mul_prod[MP_W-1:16+VAR_W] != '0) begin
                            r_var <= '1;
                        end else begin
                            r_var <= mul_prod[16 +: VAR_W];
                        end
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (unit_fin) begin
                        if (sq_root > (VAR_W/2)'(VOL_MAX)) begin
                            r_vol <= VOL_MAX;
                        end else begin
                            r_vol <= sq_root[SIAQ_W-1:0];
                        end
                        r_state <= S_WGT;
                    end
                end
                S_WGT: begin
                    if (r_vol <= V_LOW) begin
                        r_wgt   <= A_LOW;
                        r_state <= S_SCALE;
                    end else if (r_vol >= V_HIGH) begin
                        r_wgt   <= A_HIGH;
                        r_state <= S_SCALE;
                    end else if (unit_fin) begin
                        // divide by 5888 as (p >> 8) / 23
                        r_n     <= mul_prod[8 +: 20];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (unit_fin) begin
                        r_wgt   <= A_LOW + WGT_W'(mul_prod[28 +: 15]);
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (r_acc != 2'd3) begin
                        r_state <= S_CLAMP;
                    end else if (unit_fin) begin
                        r_wgt   <= mul_prod[16 +: WGT_W];
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_wgt   <= wgt_cl;
                    r_state <= S_SM1;
                end
                S_SM1: begin
                    if (!r_seeded) begin
                        r_state <= S_RING;
                    end else if (unit_fin) begin
                        r_state <= S_SM2;
                    end
                end
                S_SM2: begin
                    if (unit_fin) begin
                        r_smooth <= mul_prod[16 +: SIAQ_W];
                        r_state  <= S_RING;
                    end
                end
                S_RING: begin
                    r_seeded <= 1'b1;
                    if (ram_we) begin
                        r_dcnt <= '0;
                        r_wr   <= wr_n;
                        r_fill <= fill_n;
                        r_state <= (fill_n >= RF_W'(2)) ? S_CMP : S_OUT;
                    end else begin
                        r_dcnt  <= dcnt_n[7:0];
                        r_state <= S_OUT;
                    end
                end
                S_CMP: begin
                    if (moving) begin
                        r_frozen <= 1'b1;
                        r_stable <= '0;
                    end else if (r_frozen) begin
                        r_stable <= stable_n;
                        if (stable_n >= r_resume) begin
                            r_frozen <= 1'b0;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait for the output register to free up
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {1'b0, r_frozen, r_vol, r_acc, r_smooth, r_gas_avg};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    aqas_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    aqas_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_din   (r_var),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    aqas_ram #(
        .W (RD_W),
        .D (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata ({r_siaq, r_hum, r_pres}),
        .i_raddr (old_addr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Ring fill never exceeds the depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= RF_W'(RING_DEPTH))
        else $error("ring fill count past depth");

    // The frozen flag only drops on a stable ring check
    a_unfreeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_frozen)) |-> ($past(r_state) == S_CMP))
        else $error("frozen flag cleared outside a ring check");

    // The smoothing weight is within its clamp range when used
    a_wgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SM1 || r_state == S_SM2) |-> (r_wgt >= A_MIN && r_wgt <= A_HIGH))
        else $error("IAQ weight outside clamp range");

    // A finished sample leaves for idle once the output register is free
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_ovalid) |=> (r_state == S_IDLE && r_ovalid))
        else $error("result not loaded into free output register");
endmodule

// ----- src/aqas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module aqas_ram #(
    parameter int W = 8,
    parameter int D = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/aqas_mul.sv -----
// Shift-add serial multiply-accumulate unit, one multiplier bit per cycle.
`timescale 1ns / 1ps
module aqas_mul import aqas_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_mul_req        i_req,
    output logic            o_done,
    output logic [MP_W-1:0] o_prod
);
    logic            r_busy;
    logic [MA_W-1:0] r_a;
    logic [MP_W-1:0] r_b;
    logic [MP_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_a    <= i_req.a;
            r_b    <= {{(MP_W-MB_W){1'b0}}, i_req.b};
            r_acc  <= i_req.c;
        end else if (r_busy) begin
            if (r_a == '0) begin
                r_busy <= 1'b0;
            end else begin
                if (r_a[0]) begin
                    r_acc <= r_acc + r_b;
                end
                r_a <= r_a >> 1;
                r_b <= r_b << 1;
            end
        end
    end

    // finish as soon as no multiplier bits remain
    assign o_done = r_busy && (r_a == '0);
    assign o_prod = r_acc;
endmodule

// ----- src/aqas_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module aqas_sqrt import aqas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VAR_W-1:0]   i_din,
    output logic               o_done,
    output logic [VAR_W/2-1:0] o_root
);
    localparam int CNT_W = $clog2(VAR_W/2 + 1);
    localparam logic [VAR_W-1:0] TOP_BIT = VAR_W'(1) << (VAR_W - 2);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [VAR_W-1:0] r_v;
    logic [VAR_W-1:0] r_r;
    logic [VAR_W-1:0] r_bit;
    logic [VAR_W:0]   trial;

    assign trial = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(VAR_W/2);
            r_v    <= i_din;
            r_r    <= '0;
            r_bit  <= TOP_BIT;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                if ({1'b0, r_v} >= trial) begin
                    r_v <= r_v - trial[VAR_W-1:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_r[VAR_W/2-1:0];
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the adaptive air-quality smoother core.
`timescale 1ns / 1ps
// A directed table, then random phases under varied register settings.
// Every accepted sample is run through an in-bench predictor of the
// averages, the variance-driven weight and the transport detector. Each
// result beat is checked against the oldest waiting prediction.
module testbench;
    import aqas_pkg::*;

    localparam int          LIMIT_CYCLES = 2000000;
    localparam int          RING_N       = 8;
    localparam bit [63:0]   VAR_CAP      = 64'hFF_FFFF_FFFF;
    // index past the register list; the block must ignore it
    localparam logic [CFGA_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        bit [16:0] siaq;
        bit [1:0]  acc;
        bit [14:0] hum;
        bit [16:0] pres;
        bit [25:0] gas;
    } t_sample;

    typedef struct {
        bit [25:0] gas_avg;
        bit [16:0] iaq_disp;
        bit [1:0]  acc_disp;
        bit [16:0] vol;
        bit        frz;
    } t_reading;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [79:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;
    logic              i_cfg_we = 1'b0;
    logic [CFGA_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    air_quality_adaptive_smoother_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor registers
    bit [63:0] rg_gas_alpha, rg_var_alpha, rg_decim, rg_press_th, rg_humid_th;
    bit [63:0] rg_iaq_th, rg_resume;
    bit        p_seeded;
    bit [63:0] p_gas_avg, p_mean, p_var, p_smooth;
    int        p_decim_cnt, p_ring_wr, p_ring_fill, p_stable;
    bit        p_frozen;
    bit [63:0] p_press_ring[RING_N], p_humid_ring[RING_N], p_iaq_ring[RING_N];

    t_reading  readings_due[$];
    int        fail_count = 0;
    int        beats_sent = 0;
    int        beats_seen = 0;
    int        freeze_events = 0;
    bit        calm = 1'b0;
    int        cycle_count = 0;

    function automatic bit [63:0] blend(bit [63:0] w, bit [63:0] nv, bit [63:0] ov);
        return (w * nv + (64'd65536 - w) * ov + 64'd32768) >> 16;
    endfunction

    function automatic bit [63:0] root64(bit [63:0] v);
        bit [63:0] r = 0;
        bit [63:0] b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] absdiff(bit [63:0] a, bit [63:0] b);
        return a >= b ? a - b : b - a;
    endfunction

    task automatic predictor_reset();
        rg_gas_alpha = 6554; rg_var_alpha = 6554; rg_decim = 10;
        rg_press_th = 50; rg_humid_th = 1280; rg_iaq_th = 5120; rg_resume = 3;
        p_seeded = 0; p_gas_avg = 0; p_mean = 0; p_var = 0; p_smooth = 0;
        p_decim_cnt = 0; p_ring_wr = 0; p_ring_fill = 0; p_frozen = 0; p_stable = 0;
    endtask

    // Advance the predictor by one sample and return the reading it yields.
    task automatic smooth_sample(input t_sample s, output t_reading r);
        bit [63:0] x, dmag, d2, t, nv, vs, vol, a;
        int        nw, od;
        bit        moving;
        x = 64'(s.siaq) << 7;
        if (!p_seeded) begin
            p_gas_avg = s.gas; p_mean = x; p_var = 0; p_smooth = s.siaq;
        end else begin
            p_gas_avg = blend(rg_gas_alpha, s.gas, p_gas_avg) & 64'h3FF_FFFF;
        end
        // difference taken against the mean before its update
        dmag = absdiff(x, p_mean);
        d2 = (dmag * dmag) >> 14;
        p_mean = blend(rg_var_alpha, x, p_mean) & 64'hFF_FFFF;
        t = p_var + ((rg_var_alpha * d2) >> 16);
        nv = ((64'd65536 - rg_var_alpha) * t) >> 16;
        p_var = nv > VAR_CAP ? VAR_CAP : nv;
        vs = root64(p_var);
        vol = vs > 64'd131071 ? 64'd131071 : vs;

        // weight: linear in volatility, then accuracy scaling and clamps
        if (vol <= 512) a = 6554;
        else if (vol >= 6400) a = 29491;
        else a = 6554 + ((vol - 512) * 22937) / 5888;
        if (s.acc == 3) a = (a * 39322) >> 16;
        if (s.acc <= 1 && a < 18350) a = 18350;
        if (a < 5243) a = 5243;
        if (a > 29491) a = 29491;
        if (p_seeded) p_smooth = blend(a, s.siaq, p_smooth) & 64'h1FFFF;
        p_seeded = 1;

        p_decim_cnt++;
        if (p_decim_cnt >= int'(rg_decim)) begin
            p_decim_cnt = 0;
            p_press_ring[p_ring_wr] = s.pres;
            p_humid_ring[p_ring_wr] = s.hum;
            p_iaq_ring[p_ring_wr] = s.siaq;
            p_ring_wr = (p_ring_wr + 1) % RING_N;
            if (p_ring_fill < RING_N) p_ring_fill++;
            if (p_ring_fill >= 2) begin
                nw = (p_ring_wr + RING_N - 1) % RING_N;
                od = (p_ring_fill == RING_N) ? p_ring_wr : 0;
                moving = absdiff(p_press_ring[nw], p_press_ring[od]) > rg_press_th
                      || absdiff(p_humid_ring[nw], p_humid_ring[od]) > rg_humid_th
                      || absdiff(p_iaq_ring[nw], p_iaq_ring[od]) > rg_iaq_th;
                if (moving) begin
                    if (!p_frozen) freeze_events++;
                    p_frozen = 1; p_stable = 0;
                end else if (p_frozen) begin
                    if (p_stable < 255) p_stable++;
                    if (p_stable >= int'(rg_resume)) p_frozen = 0;
                end
            end
        end
        r.gas_avg = p_gas_avg[25:0];
        r.iaq_disp = p_smooth[16:0];
        r.acc_disp = s.acc;
        r.vol = vol[16:0];
        r.frz = p_frozen;
    endtask

    function automatic int pick_gap();
        int k;
        if (calm) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one sample beat, hold until accepted, then log its reading.
    task automatic send_sample(input t_sample s, input bit typed, input t_reading typed_r);
        int       gap;
        t_reading r;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {3'b0, s.gas, s.pres, s.hum, s.acc, s.siaq};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        smooth_sample(s, r);
        readings_due.push_back(typed ? typed_r : r);
        beats_sent++;
    endtask

    // Drop valid and wait for the block to drain before touching registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGA_W-1:0] idx, input bit [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAS_ALPHA: rg_gas_alpha = val & 64'hFFFF;
            CFG_VAR_ALPHA: rg_var_alpha = val & 64'hFFFF;
            CFG_DECIM:     rg_decim = val & 64'hFF;
            CFG_PRESS_TH:  rg_press_th = val & 64'hFFFF;
            CFG_HUMID_TH:  rg_humid_th = val & 64'h7FFF;
            CFG_IAQ_TH:    rg_iaq_th = val & 64'h1FFFF;
            CFG_RESUME:    rg_resume = val & 64'hFF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(bit [63:0] ga, bit [63:0] va, bit [63:0] dc, bit [63:0] pt,
                             bit [63:0] ht, bit [63:0] it, bit [63:0] rc);
        write_reg(CFG_GAS_ALPHA, ga);
        write_reg(CFG_VAR_ALPHA, va);
        write_reg(CFG_DECIM, dc);
        write_reg(CFG_PRESS_TH, pt);
        write_reg(CFG_HUMID_TH, ht);
        write_reg(CFG_IAQ_TH, it);
        write_reg(CFG_RESUME, rc);
    endtask

    // Result side: random stalls, check every accepted beat.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            if (readings_due.size() == 0) begin
                $error("result beat with no prediction waiting");
                fail_count++;
            end else begin
                e = readings_due.pop_front();
                if (m_axis_tdata[25:0] !== e.gas_avg) begin
                    $error("gas_average exp %0d got %0d", e.gas_avg, m_axis_tdata[25:0]);
                    fail_count++;
                end
                if (m_axis_tdata[42:26] !== e.iaq_disp) begin
                    $error("iaq_display exp %0d got %0d", e.iaq_disp, m_axis_tdata[42:26]);
                    fail_count++;
                end
                if (m_axis_tdata[44:43] !== e.acc_disp) begin
                    $error("accuracy_display exp %0d got %0d", e.acc_disp,
                           m_axis_tdata[44:43]);
                    fail_count++;
                end
                if (m_axis_tdata[61:45] !== e.vol) begin
                    $error("volatility exp %0d got %0d", e.vol, m_axis_tdata[61:45]);
                    fail_count++;
                end
                if (m_axis_tdata[62] !== e.frz) begin
                    $error("frozen exp %0d got %0d", e.frz, m_axis_tdata[62]);
                    fail_count++;
                end
            end
        end
        // pick readiness for the next edge
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                   : $urandom_range(10, 50);
            m_axis_tready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Random sample: mostly a slowly drifting environment with occasional
    // jumps (walks the ring through freeze and resume), some pure noise.
    bit [63:0] base_iaq = 25600, base_hum = 12800, base_pres = 101325, base_gas = 150000;
    function automatic t_sample random_sample();
        t_sample s;
        if ($urandom_range(0, 7) == 0) begin
            s.siaq = 17'($urandom); s.acc = 2'($urandom); s.hum = 15'($urandom);
            s.pres = 17'($urandom); s.gas = 26'($urandom);
            return s;
        end
        if ($urandom_range(0, 14) == 0) begin
            base_iaq = 64'($urandom_range(0, 128000));
            base_hum = 64'($urandom_range(0, 25600));
            base_pres = 64'($urandom_range(30000, 131071));
            base_gas = 64'($urandom_range(0, 67108863));
        end
        s.siaq = 17'(base_iaq + $urandom_range(0, 2000));
        s.acc = 2'($urandom);
        s.hum = 15'(base_hum + $urandom_range(0, 400));
        s.pres = 17'(base_pres + $urandom_range(0, 30));
        s.gas = 26'(base_gas + $urandom_range(0, 5000));
        return s;
    endfunction

    t_sample  dir_tab[$];
    t_reading dir_exp[$];
    bit       dir_typed[$];

    task automatic add_row(bit [16:0] siaq, bit [1:0] acc, bit [14:0] hum, bit [16:0] pres,
                           bit [25:0] gas, bit typed, t_reading r);
        t_sample s;
        s.siaq = siaq; s.acc = acc; s.hum = hum; s.pres = pres; s.gas = gas;
        dir_tab.push_back(s); dir_exp.push_back(r); dir_typed.push_back(typed);
    endtask

    initial begin
        t_reading none, first;
        t_sample  s;
        int       phase;
        none = '{default: 0};
        predictor_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First sample seeds the averages: result equals the sample itself.
        first = '{gas_avg: 26'h3FF_FFFF, iaq_disp: 17'h1FFFF, acc_disp: 2'd3,
                  vol: 17'd0, frz: 1'b0};
        add_row(17'h1FFFF, 2'd3, 15'h7FFF, 17'h1FFFF, 26'h3FF_FFFF, 1, first);
        add_row(17'd0, 2'd0, 15'd0, 17'd0, 26'd0, 0, none);
        add_row(17'd128000, 2'd1, 15'd25600, 17'd131071, 26'd67108863, 0, none);
        add_row(17'd25600, 2'd2, 15'd12800, 17'd101325, 26'd200000, 0, none);
        for (int k = 0; k < 8; k++)
            add_row(17'd25600 + 17'(k), 2'(k), 15'd12800, 17'd101325, 26'd200000, 0, none);
        // pressure, humidity and IAQ steps; they fall between ring writes, so they do not trip the detector
        add_row(17'd25600, 2'd3, 15'd12800, 17'd101400, 26'd210000, 0, none);
        add_row(17'd40000, 2'd0, 15'd20000, 17'd101325, 26'd190000, 0, none);
        for (int k = 0; k < 10; k++)
            add_row(17'd25600, 2'd3, 15'd12800, 17'd101325, 26'd200000, 0, none);
        for (int k = 0; k < dir_tab.size(); k++)
            send_sample(dir_tab[k], dir_typed[k], dir_exp[k]);
        drain();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                // zero weights and thresholds, decimation and resume of one: any change moves, one stable check resumes
                0: write_all(0, 0, 1, 0, 0, 0, 1);
                1: write_all(65535, 65535, 255, 65535, 25600, 128000, 255);
                // zero decimation and zero resume count, plus widths overflowed
                2: write_all($urandom, $urandom, 0, 40, 600, 3000, 0);
                3: write_all(65535, 0, 1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 2);
                default:
                    write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(1, 4), $urandom_range(0, 60),
                              $urandom_range(0, 800), $urandom_range(0, 4000),
                              $urandom_range(1, 5));
            endcase
            if (phase == 4) write_reg(CFG_UNUSED, $urandom);
            calm = (phase == 5);
            repeat (70) begin
                s = random_sample();
                send_sample(s, 0, none);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Sent %0d samples over 9 register settings, checked %0d readings.",
                 beats_sent, beats_seen);
        $display("Predicted freeze onsets: %0d.", freeze_events);
        if (fail_count == 0 && readings_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- air_quality_adaptive_smoother_core.f -----
src/aqas_pkg.sv
src/aqas_ram.sv
src/aqas_mul.sv
src/aqas_sqrt.sv
src/air_quality_adaptive_smoother_core.sv
verif/testbench.sv
